FILE: hdl/rzb_pkg.sv
// Shared types, constants and helpers for the triangle raster unit.
package rzb_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int DEPTH_BITS = 24;
  localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(STORE_SIZE);
  localparam int DIM_W      = 9;
  localparam int Y_W        = $clog2(MAX_HEIGHT);
  localparam int X_W        = $clog2(MAX_WIDTH) + 1;
  localparam int FRAC_BITS  = 16;
  localparam int THIN_LIMIT = 7;
  localparam int COORD_W    = 12;

  localparam logic [1:0] OP_DRAW  = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [15:0] vert_a_x;
    logic signed [15:0] vert_a_y;
    logic [23:0]        vert_a_depth;
    logic signed [15:0] vert_b_x;
    logic signed [15:0] vert_b_y;
    logic [23:0]        vert_b_depth;
    logic signed [15:0] vert_c_x;
    logic signed [15:0] vert_c_y;
    logic [23:0]        vert_c_depth;
    logic [31:0]        fill_colour;
    logic [15:0]        read_index;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_colour;
    logic [23:0] read_depth;
    logic [16:0] written_count;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_DRAW  = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_kind_t;

  // Vertices are already floored and sorted by y.
  typedef struct packed {
    cmd_kind_t                     kind;
    logic [2:0][COORD_W-1:0]       vx;
    logic [2:0][COORD_W-1:0]       vy;
    logic [2:0][DEPTH_BITS-1:0]    vz;
    logic [COORD_W-1:0]            dyt;
    logic [COORD_W-1:0]            dya;
    logic [COORD_W-1:0]            dyb;
    logic [31:0]                   colour;
    logic [15:0]                   rd_index;
  } cmd_t;

  typedef struct packed {
    logic        start;
    logic [55:0] num;
    logic [31:0] den;
    logic [5:0]  iters;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [55:0] quot;
  } div_rsp_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                               input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    if (v > maxv) r = maxv;
    return r;
  endfunction

endpackage

FILE: hdl/rzb_front.sv
// Front end: floors and sorts vertices, classifies each item into a command.
module rzb_front import rzb_pkg::*; (
  input  logic     push,
  input  in_item_t in_item,
  input  logic     q_full,
  output logic     q_wr,
  output cmd_t     q_cmd
);

  logic signed [COORD_W-1:0] x [3];
  logic signed [COORD_W-1:0] y [3];
  logic [DEPTH_BITS-1:0]     z [3];
  logic signed [COORD_W-1:0] tx, ty;
  logic [DEPTH_BITS-1:0]     tz;
  logic signed [COORD_W:0]   dyt, dya, dyb;

  always_comb begin
    tx = '0;
    ty = '0;
    tz = '0;
    x[0] = in_item.vert_a_x[15:4];
    y[0] = in_item.vert_a_y[15:4];
    z[0] = in_item.vert_a_depth;
    x[1] = in_item.vert_b_x[15:4];
    y[1] = in_item.vert_b_y[15:4];
    z[1] = in_item.vert_b_depth;
    x[2] = in_item.vert_c_x[15:4];
    y[2] = in_item.vert_c_y[15:4];
    z[2] = in_item.vert_c_depth;
    // three compare-swaps: (0,1) (0,2) (1,2)
    if (y[0] > y[1]) begin
      tx = x[0]; ty = y[0]; tz = z[0];
      x[0] = x[1]; y[0] = y[1]; z[0] = z[1];
      x[1] = tx; y[1] = ty; z[1] = tz;
    end
    if (y[0] > y[2]) begin
      tx = x[0]; ty = y[0]; tz = z[0];
      x[0] = x[2]; y[0] = y[2]; z[0] = z[2];
      x[2] = tx; y[2] = ty; z[2] = tz;
    end
    if (y[1] > y[2]) begin
      tx = x[1]; ty = y[1]; tz = z[1];
      x[1] = x[2]; y[1] = y[2]; z[1] = z[2];
      x[2] = tx; y[2] = ty; z[2] = tz;
    end
    dyt = 13'(y[2]) - 13'(y[0]);
    dya = 13'(y[1]) - 13'(y[0]);
    dyb = 13'(y[2]) - 13'(y[1]);

    q_cmd.vx       = {x[2], x[1], x[0]};
    q_cmd.vy       = {y[2], y[1], y[0]};
    q_cmd.vz       = {z[2], z[1], z[0]};
    q_cmd.dyt      = dyt[COORD_W-1:0];
    q_cmd.dya      = dya[COORD_W-1:0];
    q_cmd.dyb      = dyb[COORD_W-1:0];
    q_cmd.colour   = in_item.fill_colour;
    q_cmd.rd_index = in_item.read_index;
    case (in_item.op)
      OP_DRAW:  q_cmd.kind = (dyt == '0) ? CMD_NOP : CMD_DRAW;
      OP_CLEAR: q_cmd.kind = CMD_CLEAR;
      OP_READ:  q_cmd.kind = CMD_READ;
      default:  q_cmd.kind = CMD_NOP;
    endcase
  end

  assign q_wr = push && !q_full;

endmodule

FILE: hdl/rzb_queue.sv
// Two-entry command queue between front and back end.
module rzb_queue import rzb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr,
  input  cmd_t wr_cmd,
  output logic full,
  input  logic rd,
  output logic valid,
  output cmd_t rd_cmd
);

  cmd_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (wr) wr_ptr_r <= !wr_ptr_r;
      if (rd) rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + 2'(wr) - 2'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem_r[wr_ptr_r] <= wr_cmd;
  end

  assign full   = (cnt_r == 2'd2);
  assign valid  = (cnt_r != 2'd0);
  assign rd_cmd = mem_r[rd_ptr_r];

endmodule

FILE: hdl/rzb_div.sv
// Restoring divider, one quotient bit per cycle.
module rzb_div import rzb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [31:0] rem_r, den_r;
  logic [55:0] num_r, quot_r;
  logic [5:0]  cnt_r;
  logic        busy_r, done_r;
  logic [32:0] r2;
  logic        ge;

  assign r2 = {rem_r, num_r[55]};
  assign ge = (r2 >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == 6'd1) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= '0;
      den_r  <= req.den;
      num_r  <= req.num;
      quot_r <= '0;
      cnt_r  <= req.iters;
    end else if (busy_r) begin
      rem_r  <= ge ? 32'(r2 - {1'b0, den_r}) : r2[31:0];
      num_r  <= {num_r[54:0], 1'b0};
      quot_r <= {quot_r[54:0], ge};
      cnt_r  <= cnt_r - 6'd1;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

FILE: hdl/rzb_back.sv
// Back end: row/span walker with depth test, clear sweep and the two stores.
module rzb_back import rzb_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [DIM_W-1:0] width_reg,
  input  logic [DIM_W-1:0] height_reg,
  input  logic             q_valid,
  input  cmd_t             q_cmd,
  output logic             q_rd,
  output logic             res_valid,
  output out_item_t        res_item,
  input  logic             res_pop
);

  typedef enum logic [14:0] {
    S_CLR   = 15'b000000000000001,
    S_IDLE  = 15'b000000000000010,
    S_ROW   = 15'b000000000000100,
    S_DIVA  = 15'b000000000001000,
    S_DIVB  = 15'b000000000010000,
    S_MUL   = 15'b000000000100000,
    S_SPAN1 = 15'b000000001000000,
    S_SPAN2 = 15'b000000010000000,
    S_DIVS  = 15'b000000100000000,
    S_ADV   = 15'b000001000000000,
    S_PIXRD = 15'b000010000000000,
    S_PIXWR = 15'b000100000000000,
    S_RDMEM = 15'b001000000000000,
    S_DONE  = 15'b010000000000000,
    S_SKIP  = 15'b100000000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [31:0]           colour_mem [STORE_SIZE];
  logic [DEPTH_BITS-1:0] depth_mem  [STORE_SIZE];
  logic [31:0]           colour_rd_r;
  logic [DEPTH_BITS-1:0] depth_rd_r;

  cmd_t                  cmd_r;
  logic                  init_r, half_r, res_valid_r;
  logic [ADDR_W-1:0]     clr_addr_r, row_base_r, p_r;
  logic signed [13:0]    y_r, yend_r;
  logic [15:0]           fa_r, fb_r;
  logic [1:0]            mcnt_r;
  logic signed [31:0]    sx_r, ex_r;
  logic signed [41:0]    sz_r, ez_r;
  logic [X_W-1:0]        x_r, xend_r;
  logic [12:0]           k_r;
  logic [3:0]            kcnt_r;
  logic                  neg_r;
  logic signed [57:0]    d_r, step_r, stepsh_r;
  logic [16:0]           count_r;
  out_item_t             out_r;

  logic [DIM_W-1:0]      w_eff, h_eff;
  div_req_t              dreq;
  div_rsp_t              drsp;

  // row and span arithmetic
  logic signed [13:0]    v0y, v1y, v2y, hy, yoff0, yoff1;
  logic                  row_go;
  logic signed [41:0]    m_base, m_sum, m_prod;
  logic signed [24:0]    m_diff;
  logic signed [16:0]    m_frac;
  logic signed [32:0]    dx_s;
  logic signed [16:0]    tsx, tex, span_start, span_end;
  logic                  span_skip;
  logic signed [42:0]    zdiff;
  logic [42:0]           zmag;
  logic [DEPTH_BITS-1:0] dq;
  logic                  pass;
  logic [16:0]           rb_full;
  logic                  mem_we, mem_re;
  logic [ADDR_W-1:0]     mem_waddr, mem_raddr, pix_addr;
  logic [31:0]           mem_wcol;
  logic [DEPTH_BITS-1:0] mem_wdep;

  function automatic logic signed [16:0] trunc16(input logic signed [31:0] v);
    logic [31:0] a;
    a = v[31] ? 32'(-v) : v;
    return v[31] ? -$signed({1'b0, a[31:16]}) : $signed({1'b0, a[31:16]});
  endfunction

  rzb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  assign w_eff = eff_dim(width_reg, DIM_W'(MAX_WIDTH));
  assign h_eff = eff_dim(height_reg, DIM_W'(MAX_HEIGHT));

  assign v0y    = 14'($signed(cmd_r.vy[0]));
  assign v1y    = 14'($signed(cmd_r.vy[1]));
  assign v2y    = 14'($signed(cmd_r.vy[2]));
  assign hy     = $signed({5'b0, h_eff});
  assign yoff0  = y_r - v0y;
  assign yoff1  = y_r - v1y;
  assign row_go = (y_r < yend_r);

  // shared multiplier for the four span-end interpolations
  always_comb begin
    logic signed [COORD_W-1:0] xa, xb;
    logic [DEPTH_BITS-1:0]     za, zb;
    xa = (mcnt_r[1] && half_r) ? $signed(cmd_r.vx[1]) : $signed(cmd_r.vx[0]);
    za = (mcnt_r[1] && half_r) ? cmd_r.vz[1] : cmd_r.vz[0];
    xb = mcnt_r[1] ? (half_r ? $signed(cmd_r.vx[2]) : $signed(cmd_r.vx[1]))
                   : $signed(cmd_r.vx[2]);
    zb = mcnt_r[1] ? (half_r ? cmd_r.vz[2] : cmd_r.vz[1]) : cmd_r.vz[2];
    m_frac = $signed({1'b0, (mcnt_r[1] ? fb_r : fa_r)});
    if (mcnt_r[0]) begin
      m_base = $signed({2'b0, za, 16'b0});
      m_diff = $signed({1'b0, zb}) - $signed({1'b0, za});
    end else begin
      m_base = {26'(xa), 16'b0};
      m_diff = 25'(xb) - 25'(xa);
    end
  end
  assign m_prod = m_diff * m_frac;
  assign m_sum  = m_base + m_prod;

  // span setup
  always_comb begin
    dx_s       = 33'(ex_r) - 33'(sx_r);
    tsx        = trunc16(sx_r);
    tex        = trunc16(ex_r);
    span_start = tsx[16] ? '0 : tsx;
    span_end   = (tex > $signed({8'b0, w_eff})) ? $signed({8'b0, w_eff}) : tex;
    span_skip  = (dx_s < 33'(THIN_LIMIT)) || (span_start >= span_end);
    zdiff      = 43'(ez_r) - 43'(sz_r);
    zmag       = zdiff[42] ? 43'(-zdiff) : zdiff;
  end

  // depth of the current pixel, saturated
  always_comb begin
    if (d_r[57]) dq = '0;
    else if (|d_r[56:FRAC_BITS+DEPTH_BITS]) dq = '1;
    else dq = d_r[FRAC_BITS+DEPTH_BITS-1:FRAC_BITS];
  end
  assign pass     = (dq < depth_rd_r);
  assign rb_full  = 17'(y_r[Y_W-1:0] * w_eff);
  assign pix_addr = row_base_r + ADDR_W'(x_r);

  // divider requests
  always_comb begin
    dreq = '0;
    case (state_r)
      S_ROW: begin
        dreq.start = row_go;
        dreq.num   = {yoff0[12:0], 43'b0};
        dreq.den   = 32'(cmd_r.dyt);
        dreq.iters = 6'd29;
      end
      S_DIVA: begin
        dreq.start = drsp.done;
        dreq.num   = {(half_r ? yoff1[12:0] : yoff0[12:0]), 43'b0};
        dreq.den   = 32'(half_r ? cmd_r.dyb : cmd_r.dya);
        dreq.iters = 6'd29;
      end
      S_SPAN2: begin
        dreq.start = !span_skip;
        dreq.num   = {zmag[39:0], 16'b0};
        dreq.den   = dx_s[31:0];
        dreq.iters = 6'd56;
      end
      default: dreq = '0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    q_rd      = 1'b0;
    case (state_r)
      S_CLR:   if (&clr_addr_r) state_nxt = init_r ? S_IDLE : S_DONE;
      S_IDLE: begin
        if (q_valid) begin
          q_rd = 1'b1;
          case (q_cmd.kind)
            CMD_DRAW:  state_nxt = S_ROW;
            CMD_CLEAR: state_nxt = S_CLR;
            CMD_READ:  state_nxt = S_RDMEM;
            default:   state_nxt = S_DONE;
          endcase
        end
      end
      S_ROW: begin
        if (row_go) state_nxt = S_DIVA;
        else if (half_r) state_nxt = S_DONE;
      end
      S_DIVA:  if (drsp.done) state_nxt = S_DIVB;
      S_DIVB:  if (drsp.done) state_nxt = S_MUL;
      S_MUL:   if (mcnt_r == 2'd3) state_nxt = S_SPAN1;
      S_SPAN1: state_nxt = S_SPAN2;
      S_SPAN2: state_nxt = span_skip ? S_SKIP : S_DIVS;
      S_DIVS:  if (drsp.done) state_nxt = S_ADV;
      S_ADV:   if (kcnt_r == 4'd12) state_nxt = S_PIXRD;
      S_PIXRD: state_nxt = S_PIXWR;
      S_PIXWR: state_nxt = (x_r + X_W'(1) == xend_r) ? S_SKIP : S_PIXRD;
      S_SKIP:  state_nxt = S_ROW;
      S_RDMEM: state_nxt = S_DONE;
      S_DONE:  if (!res_valid_r || res_pop) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      init_r      <= 1'b1;
      clr_addr_r  <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLR) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
        if (&clr_addr_r) init_r <= 1'b0;
      end
      if (state_r == S_DONE && (!res_valid_r || res_pop)) res_valid_r <= 1'b1;
      else if (res_pop) res_valid_r <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        cmd_r   <= q_cmd;
        half_r  <= 1'b0;
        count_r <= '0;
        y_r     <= $signed(q_cmd.vy[0]) < 0 ? '0 : 14'($signed(q_cmd.vy[0]));
        yend_r  <= (14'($signed(q_cmd.vy[1])) > hy) ? hy : 14'($signed(q_cmd.vy[1]));
      end
      S_ROW: begin
        row_base_r <= rb_full[ADDR_W-1:0];
        if (!row_go && !half_r) begin
          half_r <= 1'b1;
          y_r    <= v1y[13] ? '0 : v1y;
          yend_r <= (v2y > hy) ? hy : v2y;
        end
      end
      S_DIVA: if (drsp.done) fa_r <= drsp.quot[15:0];
      S_DIVB: begin
        mcnt_r <= '0;
        if (drsp.done) fb_r <= drsp.quot[15:0];
      end
      S_MUL: begin
        mcnt_r <= mcnt_r + 2'd1;
        case (mcnt_r)
          2'd0:    sx_r <= m_sum[31:0];
          2'd1:    sz_r <= m_sum;
          2'd2:    ex_r <= m_sum[31:0];
          default: ez_r <= m_sum;
        endcase
      end
      S_SPAN1: begin
        if (sx_r > ex_r) begin
          sx_r <= ex_r;
          ex_r <= sx_r;
          sz_r <= ez_r;
          ez_r <= sz_r;
        end
      end
      S_SPAN2: begin
        x_r    <= span_start[X_W-1:0];
        xend_r <= span_end[X_W-1:0];
        k_r    <= 13'(span_start - tsx);
        neg_r  <= zdiff[42];
        d_r    <= 58'(sz_r);
        kcnt_r <= '0;
      end
      S_DIVS: begin
        if (drsp.done) begin
          step_r   <= neg_r ? -$signed({2'b0, drsp.quot}) : $signed({2'b0, drsp.quot});
          stepsh_r <= neg_r ? -$signed({2'b0, drsp.quot}) : $signed({2'b0, drsp.quot});
        end
      end
      S_ADV: begin
        // d += step * k, one bit of k per cycle
        if (k_r[0]) d_r <= d_r + stepsh_r;
        stepsh_r <= stepsh_r <<< 1;
        k_r      <= k_r >> 1;
        kcnt_r   <= kcnt_r + 4'd1;
      end
      S_PIXRD: p_r <= pix_addr;
      S_PIXWR: begin
        if (pass) count_r <= count_r + 17'd1;
        d_r <= d_r + step_r;
        x_r <= x_r + X_W'(1);
      end
      S_SKIP:  y_r <= y_r + 14'sd1;
      S_DONE: begin
        if (!res_valid_r || res_pop) begin
          case (cmd_r.kind)
            CMD_DRAW: out_r <= {32'b0, 24'b0, count_r};
            CMD_READ: out_r <= {colour_rd_r, depth_rd_r, 17'b0};
            default:  out_r <= '0;
          endcase
        end
      end
      default: ;
    endcase
  end

  // store ports
  always_comb begin
    mem_we    = (state_r == S_CLR) || (state_r == S_PIXWR && pass);
    mem_waddr = (state_r == S_CLR) ? clr_addr_r : p_r;
    mem_wcol  = (state_r == S_CLR) ? '0 : cmd_r.colour;
    mem_wdep  = (state_r == S_CLR) ? '1 : dq;
    mem_re    = (state_r == S_PIXRD) || (state_r == S_RDMEM);
    mem_raddr = (state_r == S_PIXRD) ? pix_addr : cmd_r.rd_index[ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      colour_mem[mem_waddr] <= mem_wcol;
      depth_mem[mem_waddr]  <= mem_wdep;
    end
    if (mem_re) begin
      colour_rd_r <= colour_mem[mem_raddr];
      depth_rd_r  <= depth_mem[mem_raddr];
    end
  end

  assign res_valid = res_valid_r;
  assign res_item  = out_r;

endmodule

FILE: hdl/scanline_triangle_zbuffer_raster_unit.sv
// Draw: each row runs two divides of 29 steps; a row with a span adds a divide of 56
// steps and a 13-step depth seek, then reads each span pixel and writes it if it passes.
// Read: one store read; clear: one store entry per cycle; an empty op returns a zero result.
// One item runs in the back end at a time; a 2-entry queue takes new beats meanwhile.
// Reset (synchronous, rst_n low): width/height return to 256, then a clearing pass over
// all 65536 store entries runs; items wait in the queue until it ends.
module scanline_triangle_zbuffer_raster_unit import rzb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  in_item_t    in_item,
  output logic        empty,
  input  logic        pop,
  output out_item_t   out_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [DIM_W-1:0] width_r, height_r;
  logic             q_wr, q_full, q_rd, q_valid, res_valid;
  cmd_t             wr_cmd, rd_cmd;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(MAX_WIDTH);
      height_r <= DIM_W'(MAX_HEIGHT);
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_WIDTH:  width_r  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: height_r <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign prdata = (paddr[2] == REG_HEIGHT) ? 32'(height_r) : 32'(width_r);

  rzb_front u_front (
    .push    (push),
    .in_item (in_item),
    .q_full  (q_full),
    .q_wr    (q_wr),
    .q_cmd   (wr_cmd)
  );

  rzb_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (q_wr),
    .wr_cmd (wr_cmd),
    .full   (q_full),
    .rd     (q_rd),
    .valid  (q_valid),
    .rd_cmd (rd_cmd)
  );

  rzb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .width_reg  (width_r),
    .height_reg (height_r),
    .q_valid    (q_valid),
    .q_cmd      (rd_cmd),
    .q_rd       (q_rd),
    .res_valid  (res_valid),
    .res_item   (out_item),
    .res_pop    (pop)
  );

  assign full  = q_full;
  assign empty = !res_valid;

endmodule
